### hw/rtl/lc3ae_pkg.sv
`default_nettype none

package lc3ae_pkg;

    localparam int XLEN      = 16;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = 3;

    typedef logic [XLEN-1:0]      t_word;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    typedef logic [2:0]           t_flags;

    localparam t_word    PC_RESET = 16'h3000;
    localparam t_reg_idx LINK_REG = 3'd7;

    localparam t_flags FLAG_NONE = 3'b000;
    localparam t_flags FLAG_N    = 3'b100;
    localparam t_flags FLAG_Z    = 3'b010;
    localparam t_flags FLAG_P    = 3'b001;

    typedef enum logic [3:0] {
        OP_BR   = 4'd0,
        OP_ADD  = 4'd1,
        OP_LD   = 4'd2,
        OP_ST   = 4'd3,
        OP_JSR  = 4'd4,
        OP_AND  = 4'd5,
        OP_LDR  = 4'd6,
        OP_STR  = 4'd7,
        OP_RTI  = 4'd8,
        OP_NOT  = 4'd9,
        OP_LDI  = 4'd10,
        OP_STI  = 4'd11,
        OP_JMP  = 4'd12,
        OP_RES  = 4'd13,
        OP_LEA  = 4'd14,
        OP_TRAP = 4'd15
    } t_opcode;

    // Outcome of one executed instruction; also drives the register file write.
    typedef struct packed {
        t_word    next_pc;
        logic     reg_written;
        t_reg_idx written_index;
        t_word    written_value;
        t_flags   cond_flags;
        logic     branch_taken;
        logic     unsupported;
    } t_exec_res;

endpackage

`default_nettype wire

### hw/rtl/lc3ae_ram.sv
`default_nettype none

module lc3ae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                      i_wr_data,
    input  wire logic                                  i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]                      o_rd_data_a,
    output logic      [WIDTH-1:0]                      o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, old data on a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lc3ae_regfile.sv
`default_nettype none

module lc3ae_regfile
    import lc3ae_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_rd_en,
    input  wire t_reg_idx  i_rd_addr_a,
    input  wire t_reg_idx  i_rd_addr_b,
    input  wire logic      i_wr_en,
    input  wire t_reg_idx  i_wr_addr,
    input  wire t_word     i_wr_data,
    output t_word          o_rd_data_a,
    output t_word          o_rd_data_b
);

    logic [REG_COUNT-1:0] r_valid;
    logic                 r_vld_a;
    logic                 r_vld_b;
    logic                 r_fwd_a;
    logic                 r_fwd_b;
    t_word                r_fwd_data;
    t_word                ram_a;
    t_word                ram_b;

    lc3ae_ram #(
        .WIDTH (XLEN),
        .DEPTH (REG_COUNT)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (i_wr_en),
        .i_wr_addr   (i_wr_addr),
        .i_wr_data   (i_wr_data),
        .i_rd_en     (i_rd_en),
        .i_rd_addr_a (i_rd_addr_a),
        .i_rd_addr_b (i_rd_addr_b),
        .o_rd_data_a (ram_a),
        .o_rd_data_b (ram_b)
    );

    // Registers never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_a <= r_valid[i_rd_addr_a];
                r_vld_b <= r_valid[i_rd_addr_b];
                r_fwd_a <= i_wr_en && (i_wr_addr == i_rd_addr_a);
                r_fwd_b <= i_wr_en && (i_wr_addr == i_rd_addr_b);
            end
        end
    end

    // Bypass a write landing at the same edge as the read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data_a = r_fwd_a ? r_fwd_data : (r_vld_a ? ram_a : '0);
    assign o_rd_data_b = r_fwd_b ? r_fwd_data : (r_vld_b ? ram_b : '0);

endmodule

`default_nettype wire

### hw/rtl/lc3ae_exec.sv
`default_nettype none

module lc3ae_exec
    import lc3ae_pkg::*;
(
    input  wire t_word   i_instr,
    input  wire t_word   i_pc,
    input  wire t_flags  i_flags,
    input  wire t_word   i_src_a,
    input  wire t_word   i_src_b,
    output t_exec_res    o_res
);

    t_opcode op;
    t_word   pc_inc;
    t_word   imm5;
    t_word   off9;
    t_word   off11;
    t_word   operand;

    assign op      = t_opcode'(i_instr[15:12]);
    assign pc_inc  = i_pc + 16'd1;
    assign imm5    = {{11{i_instr[4]}}, i_instr[4:0]};
    assign off9    = {{7{i_instr[8]}}, i_instr[8:0]};
    assign off11   = {{5{i_instr[10]}}, i_instr[10:0]};
    assign operand = i_instr[5] ? imm5 : i_src_b;

    always_comb begin
        o_res               = '0;
        o_res.next_pc       = pc_inc;
        o_res.cond_flags    = i_flags;
        unique case (op) inside
            OP_ADD, OP_AND, OP_NOT: begin
                o_res.reg_written   = 1'b1;
                o_res.written_index = i_instr[11:9];
                if (op == OP_ADD) begin
                    o_res.written_value = i_src_a + operand;
                end else if (op == OP_AND) begin
                    o_res.written_value = i_src_a & operand;
                end else begin
                    o_res.written_value = ~i_src_a;
                end
                if (o_res.written_value == '0) begin
                    o_res.cond_flags = FLAG_Z;
                end else if (o_res.written_value[XLEN-1]) begin
                    o_res.cond_flags = FLAG_N;
                end else begin
                    o_res.cond_flags = FLAG_P;
                end
            end
            OP_BR: begin
                if ((i_instr[11:9] & i_flags) != FLAG_NONE) begin
                    o_res.next_pc      = pc_inc + off9;
                    o_res.branch_taken = 1'b1;
                end
            end
            OP_JMP: begin
                o_res.next_pc      = i_src_a;
                o_res.branch_taken = 1'b1;
            end
            OP_JSR: begin
                // Link goes to R7; flags untouched.
                o_res.next_pc       = i_instr[11] ? (pc_inc + off11) : i_src_a;
                o_res.branch_taken  = 1'b1;
                o_res.reg_written   = 1'b1;
                o_res.written_index = LINK_REG;
                o_res.written_value = pc_inc;
            end
            OP_LD, OP_ST, OP_LDR, OP_STR, OP_RTI, OP_LDI, OP_STI, OP_RES,
            OP_LEA, OP_TRAP: begin
                o_res.unsupported = 1'b1;
            end
            default: begin
                o_res.unsupported = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/lc3_alu_branch_execute_unit.sv
`default_nettype none
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     i_instruction
// result    out        o_out_valid / i_out_stall   o_next_pc, o_reg_written, o_written_index,
//                                                  o_written_value, o_cond_flags,
//                                                  o_branch_taken, o_unsupported
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_data (start PC)
//
// One instruction per cycle while the result is not stalled; a request enters the input register when
// accepted, with its register file read, and is then executed into the result register.
// The single execute pass updates PC, flags and registers for each executed instruction.
// Reset clears the register file (through valid bits), the flags, and loads the PC with 0x3000.
// A stalled result holds; a valid input register holds behind it and o_in_stall rises.
// A configuration write loads the PC directly; it is always ready.

module lc3_alu_branch_execute_unit
    import lc3ae_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_instruction,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_next_pc,
    output logic             o_reg_written,
    output logic [2:0]       o_written_index,
    output logic [15:0]      o_written_value,
    output logic [2:0]       o_cond_flags,
    output logic             o_branch_taken,
    output logic             o_unsupported,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    logic      r_in_valid;
    t_word     r_instr;
    t_word     r_pc;
    t_flags    r_cc;
    logic      r_out_valid;
    t_exec_res r_out;
    logic      in_accept;
    logic      exec_fire;
    t_word     src_a;
    t_word     src_b;
    t_exec_res res;

    // Advance the execute stage when the result register is free or being drained.
    assign exec_fire  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !exec_fire;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Operand read is launched at acceptance so the data lines up with r_instr.
    lc3ae_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_accept),
        .i_rd_addr_a (i_instruction[8:6]),
        .i_rd_addr_b (i_instruction[2:0]),
        .i_wr_en     (exec_fire && res.reg_written),
        .i_wr_addr   (res.written_index),
        .i_wr_data   (res.written_value),
        .o_rd_data_a (src_a),
        .o_rd_data_b (src_b)
    );

    lc3ae_exec u_exec (
        .i_instr (r_instr),
        .i_pc    (r_pc),
        .i_flags (r_cc),
        .i_src_a (src_a),
        .i_src_b (src_b),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= PC_RESET;
            r_cc        <= FLAG_NONE;
        end else begin
            // Take a new request whenever the input register frees up.
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (exec_fire) begin
                r_in_valid <= 1'b0;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // Commit architectural state; a config write reloads the PC.
            if (i_cfg_valid && o_cfg_ready) begin
                r_pc <= i_cfg_data;
            end else if (exec_fire) begin
                r_pc <= res.next_pc;
            end
            if (exec_fire) begin
                r_cc <= res.cond_flags;
            end
        end
    end

    // Payload registers: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_instr <= i_instruction;
        end
        if (exec_fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_next_pc       = r_out.next_pc;
    assign o_reg_written   = r_out.reg_written;
    assign o_written_index = r_out.written_index;
    assign o_written_value = r_out.written_value;
    assign o_cond_flags    = r_out.cond_flags;
    assign o_branch_taken  = r_out.branch_taken;
    assign o_unsupported   = r_out.unsupported;

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire |=> o_out_valid)
        else $error("executed request produced no result");

    a_unsup_no_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_unsupported |-> !o_reg_written && !o_branch_taken)
        else $error("unsupported opcode wrote a register or branched");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_reg_written |-> o_written_index == 3'd0 && o_written_value == 16'd0)
        else $error("write fields nonzero without a register write");

    a_flags_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_cond_flags))
        else $error("more than one condition flag set");

endmodule

`default_nettype wire

### verif/lc3_alu_branch_execute_unit_tb.sv
`default_nettype none

module lc3_alu_branch_execute_unit_tb;
    import lc3ae_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [15:0] i_instruction = '0;
    logic        i_out_stall   = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [15:0] i_cfg_data    = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_next_pc;
    logic        o_reg_written;
    logic [2:0]  o_written_index;
    logic [15:0] o_written_value;
    logic [2:0]  o_cond_flags;
    logic        o_branch_taken;
    logic        o_unsupported;
    logic        o_cfg_ready;

    lc3_alu_branch_execute_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_instruction   (i_instruction),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_next_pc       (o_next_pc),
        .o_reg_written   (o_reg_written),
        .o_written_index (o_written_index),
        .o_written_value (o_written_value),
        .o_cond_flags    (o_cond_flags),
        .o_branch_taken  (o_branch_taken),
        .o_unsupported   (o_unsupported),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Architectural state as the instruction stream should leave it.
    t_word  arch_regs [REG_COUNT];
    t_word  arch_pc;
    t_flags arch_flags;

    // Outcomes of accepted requests, oldest first.
    t_exec_res pending_results [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    function automatic t_flags flags_for(input t_word value);
        if (value == '0) return FLAG_Z;
        if (value[XLEN-1]) return FLAG_N;
        return FLAG_P;
    endfunction

    // Execute one instruction against the architectural state and return its outcome.
    function automatic t_exec_res exec_instr(input t_word instr);
        t_exec_res res;
        t_opcode   op;
        t_word     operand;
        t_word     target;
        res = '0;
        op  = t_opcode'(instr[15:12]);
        arch_pc = arch_pc + 16'd1;
        case (op)
            OP_ADD, OP_AND: begin
                operand = instr[5] ? {{11{instr[4]}}, instr[4:0]} : arch_regs[instr[2:0]];
                if (op == OP_ADD)
                    res.written_value = arch_regs[instr[8:6]] + operand;
                else
                    res.written_value = arch_regs[instr[8:6]] & operand;
                res.reg_written   = 1'b1;
                res.written_index = instr[11:9];
            end
            OP_NOT: begin
                res.written_value = ~arch_regs[instr[8:6]];
                res.reg_written   = 1'b1;
                res.written_index = instr[11:9];
            end
            OP_BR: begin
                if ((instr[11:9] & arch_flags) != FLAG_NONE) begin
                    arch_pc = arch_pc + {{7{instr[8]}}, instr[8:0]};
                    res.branch_taken = 1'b1;
                end
            end
            OP_JMP: begin
                arch_pc = arch_regs[instr[8:6]];
                res.branch_taken = 1'b1;
            end
            OP_JSR: begin
                // Read the base before the link lands, so JSRR R7 uses the old R7.
                target = instr[11] ? arch_pc + {{5{instr[10]}}, instr[10:0]}
                                   : arch_regs[instr[8:6]];
                res.written_value = arch_pc;
                res.reg_written   = 1'b1;
                res.written_index = LINK_REG;
                res.branch_taken  = 1'b1;
                arch_pc = target;
            end
            default: res.unsupported = 1'b1;
        endcase
        if (res.reg_written) begin
            arch_regs[res.written_index] = res.written_value;
            if (op != OP_JSR) arch_flags = flags_for(res.written_value);
        end
        res.next_pc    = arch_pc;
        res.cond_flags = arch_flags;
        return res;
    endfunction

    // Track reset, start PC writes and accepted requests on the same edge the block sees them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (arch_regs[i]) arch_regs[i] = '0;
            arch_pc    = PC_RESET;
            arch_flags = FLAG_NONE;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                arch_pc = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall)
                pending_results.push_back(exec_instr(i_instruction));
        end
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0d] mismatch: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
            flag_error($sformatf("%s expected %h, actual %h", name, want, got));
    endtask

    // Compare every accepted result with the oldest outstanding request.
    always @(posedge i_clk) begin : result_check
        t_exec_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result with no request outstanding, next_pc %h",
                                     o_next_pc));
            end else begin
                want = pending_results.pop_front();
                check_field("next_pc",       want.next_pc,       o_next_pc);
                check_field("reg_written",   16'(want.reg_written),   16'(o_reg_written));
                check_field("written_index", 16'(want.written_index), 16'(o_written_index));
                check_field("written_value", want.written_value, o_written_value);
                check_field("cond_flags",    16'(want.cond_flags),    16'(o_cond_flags));
                check_field("branch_taken",  16'(want.branch_taken),  16'(o_branch_taken));
                check_field("unsupported",   16'(want.unsupported),   16'(o_unsupported));
            end
        end
    end

    // Stall the result channel at the rate of the current phase.
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Watchdog: end the run as failed once cycle_count reaches CYCLE_LIMIT, whether or not traffic still moves.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one request, idling first at the phase rate; return on the accepting edge.
    // Valid stays high into the next request unless a gap or a drain drops it.
    task automatic send_instr(input t_word instr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_instruction <= instr;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and hold until every outstanding request has produced its result.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Load the start PC while the block is idle.
    task automatic write_start_pc(input t_word value);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly executable opcodes with random fields; the rest is any word at all.
    function automatic t_word random_instr();
        t_word       word;
        int unsigned pick;
        word = t_word'($urandom);
        pick = $urandom_range(99);
        if (pick < 22)      word[15:12] = OP_ADD;
        else if (pick < 40) word[15:12] = OP_AND;
        else if (pick < 52) word[15:12] = OP_NOT;
        else if (pick < 70) word[15:12] = OP_BR;
        else if (pick < 78) word[15:12] = OP_JMP;
        else if (pick < 88) word[15:12] = OP_JSR;
        return word;
    endfunction

    // ADD/AND in both operand forms and NOT; the leading BR runs with no flag set yet.
    task automatic test_alu_ops();
        send_instr({OP_BR,  3'b111, 9'h0FF});
        send_instr({OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10});
        send_instr({OP_ADD, 3'd2, 3'd1, 1'b1, 5'h0F});
        send_instr({OP_ADD, 3'd3, 3'd2, 1'b0, 2'b11, 3'd2});
        send_instr({OP_AND, 3'd4, 3'd3, 1'b1, 5'h00});
        send_instr({OP_AND, 3'd5, 3'd2, 1'b0, 2'b00, 3'd1});
        send_instr({OP_NOT, 3'd6, 3'd5, 6'h3F});
    endtask

    // Empty mask, taken and untaken conditions, both offset extremes.
    task automatic test_branches();
        send_instr(16'h0000);
        send_instr({OP_BR,  3'b001, 9'h100});
        send_instr({OP_BR,  3'b100, 9'h0FF});
        send_instr({OP_AND, 3'd4, 3'd4, 1'b1, 5'h00});
        send_instr({OP_BR,  3'b010, 9'h1FF});
    endtask

    // JMP, JSR at both offset extremes, JSRR through the link register itself.
    task automatic test_jumps();
        send_instr({OP_JMP, 3'd0, 3'd5, 6'h00});
        send_instr({OP_JSR, 1'b1, 11'h3FF});
        send_instr({OP_JSR, 1'b1, 11'h400});
        send_instr({OP_JSR, 1'b0, 2'b00, 3'd7, 6'h00});
        send_instr({OP_JSR, 1'b0, 2'b11, 3'd2, 6'h3F});
    endtask

    // Every opcode the block does not execute; TRAP goes in as an all-ones word.
    task automatic test_unsupported();
        t_opcode skipped [10];
        skipped = '{OP_LD, OP_ST, OP_LDR, OP_STR, OP_RTI, OP_LDI, OP_STI, OP_RES, OP_LEA,
                    OP_TRAP};
        foreach (skipped[i])
            send_instr({skipped[i], (skipped[i] == OP_TRAP) ? 12'hFFF
                                                           : 12'($urandom)});
    endtask

    // Start PC at both extremes: the top one wraps on the first fetch.
    task automatic test_start_pc();
        write_start_pc(16'hFFFF);
        send_instr({OP_ADD, 3'd0, 3'd0, 1'b1, 5'h01});
        send_instr({OP_BR,  3'b111, 9'h1FF});
        write_start_pc(16'h0000);
        send_instr({OP_BR,  3'b001, 9'h1FE});
        send_instr({OP_JSR, 1'b1, 11'h7FF});
    endtask

    task automatic run_random_phase(input int count, input int unsigned idle_pct,
                                    input int unsigned stall_pct);
        write_start_pc(t_word'($urandom));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_instr(random_instr());
        // Hold off the sender until the block has emptied.
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_alu_ops();
        test_branches();
        test_jumps();
        test_unsupported();
        test_start_pc();

        run_random_phase(460, 0, 0);
        run_random_phase(460, 86, 0);
        run_random_phase(460, 0, 86);
        run_random_phase(460, 19, 19);
        write_start_pc(PC_RESET);
        send_instr(random_instr());

        drain_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", error_count,
                     pending_results.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
